// ===== rtl/rpm_pkg.sv =====
// ----------------------------------------------------------------------------
// Radix page map package
// Transfer payload types, request codes and reset constants shared by the
// radix page map block and its channels.
// ----------------------------------------------------------------------------
package rpm_pkg;

  // Request codes carried in req_type.
  localparam logic REQ_LOOKUP = 1'b0;
  localparam logic REQ_INSERT = 1'b1;

  // Reset value of the running minimum id.
  localparam logic [31:0] MIN_ID_RESET = 32'd1000000000;

  typedef struct packed {
    logic        req_type;
    logic [31:0] id;
    logic [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic        found;
    logic [31:0] read_value;
    logic        out_of_pages;
    logic [31:0] min_id;
    logic [31:0] max_id;
  } out_item_t;

endpackage

// ===== rtl/rpm_chan_if.sv =====
// ----------------------------------------------------------------------------
// Radix page map channel
// Valid/ready channel; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
interface rpm_chan_if #(
  parameter type data_t = logic
);
  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/rpm_ram.sv =====
// ----------------------------------------------------------------------------
// Radix page map RAM
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module rpm_ram #(
  parameter int  WIDTH = 33,
  parameter int  DEPTH = 16384,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/radix_page_map.sv =====
// ----------------------------------------------------------------------------
// Radix page map
// Sparse id-to-value map kept as a multi-level radix page table in one RAM.
// ----------------------------------------------------------------------------
// Sequence: IDLE takes the input and issues the first RAM read, WALK checks
//   the interior levels in turn and LEAF checks the leaf entry; a last-leaf
//   cache hit goes from IDLE straight to LEAF, an insert that misses links
//   fresh pages in ALLOC and writes the value in FILL; a lookup that stops on
//   a missing page, or an insert the pool cannot cover, finishes in WALK.
// Throughput: one item at a time; the next input transfer is taken in the
//   cycle after the result is loaded into the output register.
// Reset: synchronous, active low; then a clearing pass writes all
//   PAGE_POOL * 2**LEVEL_BITS RAM entries invalid (16384 by default), no input.
// ----------------------------------------------------------------------------
module radix_page_map #(
  parameter int ID_WIDTH    = 32,
  parameter int LEVEL_BITS  = 8,
  parameter int PAGE_POOL   = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  rpm_chan_if.sink   in_chan,
  rpm_chan_if.source out_chan
);

  // --------------------------------------------------------------------------
  // Derived sizes.
  // The id is split into LEVELS fields, most significant first. The padded id
  // carries one extra all-zero field on top so that the leaf tag (everything
  // above the leaf slot) is never empty, even with a single level.
  // --------------------------------------------------------------------------
  localparam int LEVELS    = (ID_WIDTH + LEVEL_BITS - 1) / LEVEL_BITS;
  localparam int PAD_W     = (LEVELS + 1) * LEVEL_BITS;
  localparam int FIELD_TOP = LEVELS * LEVEL_BITS - 1;
  localparam int TAG_W     = PAD_W - LEVEL_BITS;
  localparam int PAGE_W    = $clog2(PAGE_POOL);
  localparam int ADDR_W    = PAGE_W + LEVEL_BITS;
  localparam int DEPTH     = PAGE_POOL * (2 ** LEVEL_BITS);
  localparam int VAL_W     = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;
  localparam int DATA_W    = (VAL_W > PAGE_W) ? VAL_W : PAGE_W;
  localparam int MEM_W     = DATA_W + 1;
  localparam int LVL_W     = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int CNT_W     = $clog2(PAGE_POOL + 1);
  localparam int SUM_W     = CNT_W + LVL_W;

  // Level index of the last interior level; the leaf page follows it.
  localparam logic [LVL_W-1:0] LAST_INT  = LVL_W'(LEVELS - 2);
  localparam logic [LVL_W-1:0] INT_COUNT = LVL_W'(LEVELS - 1);

  // --------------------------------------------------------------------------
  // Sequencer states.
  // CLEAR : clearing pass after reset, one RAM entry per cycle.
  // IDLE  : waits for an input transfer and issues the first RAM read.
  // WALK  : checks the interior entry read last cycle and reads the next one.
  // ALLOC : links one fresh page per cycle for an insert that missed.
  // FILL  : writes the value into a freshly allocated leaf page.
  // LEAF  : checks the leaf entry; an insert writes it back in this cycle.
  // DONE  : holds a finished result until the output register is free.
  // --------------------------------------------------------------------------
  typedef enum logic [6:0] {
    ST_CLEAR = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_WALK  = 7'b0000100,
    ST_ALLOC = 7'b0001000,
    ST_FILL  = 7'b0010000,
    ST_LEAF  = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  // Control state.
  logic [ADDR_W-1:0]   clr_addr_r, clr_addr_nxt;
  logic [CNT_W-1:0]    pages_used_r, pages_used_nxt;
  logic [31:0]         lowest_r, lowest_nxt;
  logic [31:0]         highest_r, highest_nxt;
  logic [TAG_W-1:0]    cache_tag_r, cache_tag_nxt;
  logic [PAGE_W-1:0]   cache_page_r, cache_page_nxt;
  logic                cache_valid_r, cache_valid_nxt;
  logic                out_valid_r, out_valid_nxt;

  // Per-item working registers.
  logic                insert_r, insert_nxt;
  logic [PAD_W-1:0]    id_pad_r, id_pad_nxt;
  logic [PAD_W-1:0]    walk_sh_r, walk_sh_nxt;
  logic [VAL_W-1:0]    val_r, val_nxt;
  logic [PAGE_W-1:0]   page_r, page_nxt;
  logic [LVL_W-1:0]    level_r, level_nxt;
  rpm_pkg::out_item_t  res_r, res_nxt;
  rpm_pkg::out_item_t  out_data_r, out_data_nxt;

  // RAM ports.
  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [MEM_W-1:0]    ram_wdata;
  logic [ADDR_W-1:0]   ram_raddr;
  logic [MEM_W-1:0]    ram_rdata;

  // Helpers.
  logic [PAD_W-1:0]    in_pad;
  logic [TAG_W-1:0]    in_tag;
  logic                cache_hit;
  logic                rd_valid;
  logic [PAGE_W-1:0]   rd_page;
  logic [31:0]         rd_val32;
  logic [LEVEL_BITS-1:0] leaf_slot;
  logic [LEVEL_BITS-1:0] cur_slot;
  logic [LEVEL_BITS-1:0] next_slot;
  logic [PAD_W-1:0]    next_sh;
  logic [31:0]         id32;
  logic [LVL_W-1:0]    missing;
  logic [SUM_W-1:0]    pages_needed;
  logic                pool_short;
  logic                out_free;
  logic                finish;
  rpm_pkg::out_item_t  res_cmb;

  // Every RAM word is a valid bit on top of either a child page number
  // (interior levels) or a stored value (leaf level).
  rpm_ram #(
    .WIDTH (MEM_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Ids are masked to ID_WIDTH bits before use.
  assign in_pad    = PAD_W'(in_chan.data.id[ID_WIDTH-1:0]);
  assign in_tag    = in_pad[PAD_W-1:LEVEL_BITS];
  assign cache_hit = cache_valid_r && (cache_tag_r == in_tag);

  assign rd_valid  = ram_rdata[MEM_W-1];
  assign rd_page   = ram_rdata[PAGE_W-1:0];
  assign rd_val32  = 32'(ram_rdata[VAL_W-1:0]);

  // walk_sh_r keeps the slot of the current level in its field at FIELD_TOP.
  assign leaf_slot = id_pad_r[LEVEL_BITS-1:0];
  assign cur_slot  = walk_sh_r[FIELD_TOP -: LEVEL_BITS];
  assign next_sh   = walk_sh_r << LEVEL_BITS;
  assign next_slot = next_sh[FIELD_TOP -: LEVEL_BITS];
  assign id32      = 32'(id_pad_r[ID_WIDTH-1:0]);

  // An insert is all or nothing: the pool must cover every missing page.
  assign missing      = INT_COUNT - level_r;
  assign pages_needed = SUM_W'(pages_used_r) + SUM_W'(missing);
  assign pool_short   = pages_needed > SUM_W'(PAGE_POOL);

  // The output register takes a new result when empty or being drained.
  assign out_free = !out_valid_r || out_chan.ready;

  assign in_chan.ready  = (state_r == ST_IDLE);
  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_data_r;

  always_comb begin
    state_nxt       = state_r;
    clr_addr_nxt    = clr_addr_r;
    pages_used_nxt  = pages_used_r;
    lowest_nxt      = lowest_r;
    highest_nxt     = highest_r;
    cache_tag_nxt   = cache_tag_r;
    cache_page_nxt  = cache_page_r;
    cache_valid_nxt = cache_valid_r;
    out_valid_nxt   = out_valid_r && !out_chan.ready;
    out_data_nxt    = out_data_r;
    insert_nxt      = insert_r;
    id_pad_nxt      = id_pad_r;
    walk_sh_nxt     = walk_sh_r;
    val_nxt         = val_r;
    page_nxt        = page_r;
    level_nxt       = level_r;
    res_nxt         = res_r;
    ram_we          = 1'b0;
    ram_waddr       = '0;
    ram_wdata       = '0;
    ram_raddr       = '0;
    finish          = 1'b0;
    res_cmb         = '0;

    unique case (state_r)
      ST_CLEAR: begin
        ram_we       = 1'b1;
        ram_waddr    = clr_addr_r;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == ADDR_W'(DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_chan.valid) begin
          insert_nxt  = (in_chan.data.req_type == rpm_pkg::REQ_INSERT);
          id_pad_nxt  = in_pad;
          walk_sh_nxt = in_pad;
          val_nxt     = VAL_W'(in_chan.data.value);
          level_nxt   = '0;
          if (LEVELS == 1) begin
            // The top page is the leaf page.
            page_nxt  = '0;
            ram_raddr = {PAGE_W'(0), in_pad[LEVEL_BITS-1:0]};
            state_nxt = ST_LEAF;
          end else if (cache_hit) begin
            // Same leaf page as the last walk: skip the interior levels.
            page_nxt  = cache_page_r;
            ram_raddr = {cache_page_r, in_pad[LEVEL_BITS-1:0]};
            state_nxt = ST_LEAF;
          end else begin
            page_nxt  = '0;
            ram_raddr = {PAGE_W'(0), in_pad[FIELD_TOP -: LEVEL_BITS]};
            state_nxt = ST_WALK;
          end
        end
      end

      ST_WALK: begin
        if (rd_valid) begin
          page_nxt = rd_page;
          if (level_r == LAST_INT) begin
            ram_raddr = {rd_page, leaf_slot};
            state_nxt = ST_LEAF;
          end else begin
            ram_raddr   = {rd_page, next_slot};
            walk_sh_nxt = next_sh;
            level_nxt   = level_r + 1'b1;
          end
        end else if (!insert_r) begin
          // A lookup that misses an interior page finds nothing.
          finish          = 1'b1;
          cache_valid_nxt = 1'b0;
          cache_tag_nxt   = id_pad_r[PAD_W-1:LEVEL_BITS];
          cache_page_nxt  = page_r;
        end else if (pool_short) begin
          finish               = 1'b1;
          res_cmb.out_of_pages = 1'b1;
        end else begin
          state_nxt = ST_ALLOC;
        end
      end

      ST_ALLOC: begin
        // Fresh pages were cleared after reset and pages are never freed,
        // so a newly linked page already reads as empty.
        ram_we         = 1'b1;
        ram_waddr      = {page_r, cur_slot};
        ram_wdata      = {1'b1, DATA_W'(pages_used_r[PAGE_W-1:0])};
        page_nxt       = pages_used_r[PAGE_W-1:0];
        pages_used_nxt = pages_used_r + 1'b1;
        if (level_r == LAST_INT) begin
          state_nxt = ST_FILL;
        end else begin
          walk_sh_nxt = next_sh;
          level_nxt   = level_r + 1'b1;
        end
      end

      ST_FILL: begin
        ram_we          = 1'b1;
        ram_waddr       = {page_r, leaf_slot};
        ram_wdata       = {1'b1, DATA_W'(val_r)};
        finish          = 1'b1;
        res_cmb.found   = 1'b1;
        lowest_nxt      = (id32 < lowest_r) ? id32 : lowest_r;
        highest_nxt     = (id32 > highest_r) ? id32 : highest_r;
        cache_valid_nxt = 1'b1;
        cache_tag_nxt   = id_pad_r[PAD_W-1:LEVEL_BITS];
        cache_page_nxt  = page_r;
      end

      ST_LEAF: begin
        finish             = 1'b1;
        res_cmb.found      = 1'b1;
        res_cmb.read_value = rd_valid ? rd_val32 : 32'd0;
        cache_valid_nxt    = 1'b1;
        cache_tag_nxt      = id_pad_r[PAD_W-1:LEVEL_BITS];
        cache_page_nxt     = page_r;
        if (insert_r) begin
          // Read-modify-write: the old value was read last cycle.
          ram_we      = 1'b1;
          ram_waddr   = {page_r, leaf_slot};
          ram_wdata   = {1'b1, DATA_W'(val_r)};
          lowest_nxt  = (id32 < lowest_r) ? id32 : lowest_r;
          highest_nxt = (id32 > highest_r) ? id32 : highest_r;
        end
      end

      ST_DONE: begin
        if (out_free) begin
          out_data_nxt  = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // A finished result goes straight to the output register when it is free.
    if (finish) begin
      res_cmb.min_id = lowest_nxt;
      res_cmb.max_id = highest_nxt;
      if (out_free) begin
        out_data_nxt  = res_cmb;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end else begin
        res_nxt   = res_cmb;
        state_nxt = ST_DONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_CLEAR;
      clr_addr_r    <= '0;
      pages_used_r  <= CNT_W'(1);
      lowest_r      <= rpm_pkg::MIN_ID_RESET;
      highest_r     <= '0;
      cache_tag_r   <= '0;
      cache_page_r  <= '0;
      cache_valid_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      clr_addr_r    <= clr_addr_nxt;
      pages_used_r  <= pages_used_nxt;
      lowest_r      <= lowest_nxt;
      highest_r     <= highest_nxt;
      cache_tag_r   <= cache_tag_nxt;
      cache_page_r  <= cache_page_nxt;
      cache_valid_r <= cache_valid_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    insert_r   <= insert_nxt;
    id_pad_r   <= id_pad_nxt;
    walk_sh_r  <= walk_sh_nxt;
    val_r      <= val_nxt;
    page_r     <= page_nxt;
    level_r    <= level_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

`ifndef SYNTHESIS
  // The page count always includes the top page and never passes the pool.
  a_pool_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (pages_used_r != '0) && (pages_used_r <= CNT_W'(PAGE_POOL)))
    else $error("page count out of range");

  // The pool check before allocation leaves a free page for every link.
  a_alloc_room: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ALLOC) |-> (pages_used_r < CNT_W'(PAGE_POOL)))
    else $error("page allocated beyond the pool");

  // The cached leaf page is always an allocated page.
  a_cache_page: assert property (@(posedge clk) disable iff (!rst_n)
    cache_valid_r |-> (CNT_W'(cache_page_r) < pages_used_r))
    else $error("cached leaf page not allocated");

  // A failed insert reports nothing found and no old value.
  a_oop_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.out_of_pages) |->
      (!out_data_r.found && (out_data_r.read_value == 32'd0)))
    else $error("out-of-pages result carries data");
`endif

endmodule

// ===== bench/rpm_reply_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Radix page map reply checker
// Watches both channels of the radix page map, keeps its own copy of the page
// table, and compares every result transfer with the predicted reply.
// ----------------------------------------------------------------------------
module rpm_reply_checker #(
  parameter int ID_WIDTH    = 32,
  parameter int LEVEL_BITS  = 8,
  parameter int PAGE_POOL   = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  rpm_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  rpm_pkg::out_item_t out_data,
  output int                 mismatches,
  output int                 pending,
  output int                 replies_seen,
  output int                 refusals
);

  localparam int LEVELS       = (ID_WIDTH + LEVEL_BITS - 1) / LEVEL_BITS;
  localparam int PAGE_ENTRIES = 1 << LEVEL_BITS;
  localparam int STORE_DEPTH  = PAGE_POOL * PAGE_ENTRIES;
  localparam logic [31:0] ID_MASK =
    (ID_WIDTH >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << ID_WIDTH) - 64'd1);
  localparam logic [31:0] VALUE_MASK =
    (VALUE_WIDTH >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << VALUE_WIDTH) - 64'd1);

  // Shadow page table: entry words hold child page numbers or leaf values.
  logic [31:0] slot_word [STORE_DEPTH];
  bit          slot_live [STORE_DEPTH];
  int          pages_taken  = 1;
  logic [31:0] lowest_seen  = rpm_pkg::MIN_ID_RESET;
  logic [31:0] highest_seen = '0;

  rpm_pkg::out_item_t expected_replies [$];
  rpm_pkg::out_item_t want;
  rpm_pkg::out_item_t predicted;

  initial begin
    mismatches   = 0;
    pending      = 0;
    replies_seen = 0;
    refusals     = 0;
  end

  function automatic logic [31:0] level_field(logic [31:0] key, int lvl);
    int shift;
    shift = (LEVELS - 1 - lvl) * LEVEL_BITS;
    if (shift >= 32) return '0;
    return (key >> shift) & (PAGE_ENTRIES - 1);
  endfunction

  function automatic int slot_index(int page, logic [31:0] field);
    return (page * PAGE_ENTRIES + int'(field & (PAGE_ENTRIES - 1))) % STORE_DEPTH;
  endfunction

  // Applies one request to the shadow table and returns the reply it causes.
  function automatic rpm_pkg::out_item_t predict_access(rpm_pkg::in_item_t req);
    logic [31:0]        key;
    logic [31:0]        val;
    int                 page;
    int                 depth;
    int                 idx;
    int                 fresh;
    int                 lvl;
    int                 k;
    bit                 walking;
    rpm_pkg::out_item_t reply;
    key     = req.id & ID_MASK;
    val     = req.value & VALUE_MASK;
    reply   = '0;
    page    = 0;
    depth   = 0;
    walking = 1'b1;
    while (walking && depth + 1 < LEVELS) begin
      idx = slot_index(page, level_field(key, depth));
      if (!slot_live[idx]) begin
        walking = 1'b0;
      end else begin
        page  = int'(slot_word[idx] % PAGE_POOL);
        depth = depth + 1;
      end
    end
    if (req.req_type == rpm_pkg::REQ_LOOKUP) begin
      if (depth + 1 >= LEVELS) begin
        reply.found = 1'b1;
        idx = slot_index(page, key);
        if (slot_live[idx]) reply.read_value = slot_word[idx];
      end
    end else if (pages_taken + (LEVELS - 1 - depth) > PAGE_POOL) begin
      // All or nothing: a short pool leaves the table untouched.
      reply.out_of_pages = 1'b1;
    end else begin
      for (lvl = depth; lvl + 1 < LEVELS; lvl++) begin
        fresh       = pages_taken % PAGE_POOL;
        pages_taken = pages_taken + 1;
        for (k = 0; k < PAGE_ENTRIES; k++) slot_live[slot_index(fresh, k)] = 1'b0;
        idx            = slot_index(page, level_field(key, lvl));
        slot_word[idx] = fresh;
        slot_live[idx] = 1'b1;
        page           = fresh;
      end
      idx = slot_index(page, key);
      if (slot_live[idx]) reply.read_value = slot_word[idx];
      slot_word[idx] = val;
      slot_live[idx] = 1'b1;
      reply.found    = 1'b1;
      if (key < lowest_seen) lowest_seen = key;
      if (key > highest_seen) highest_seen = key;
    end
    reply.min_id = lowest_seen;
    reply.max_id = highest_seen;
    return reply;
  endfunction

  task automatic check_field(string name, logic [31:0] expected, logic [31:0] actual);
    if (actual !== expected) begin
      $error("%s mismatch: expected 0x%08h, got 0x%08h", name, expected, actual);
      mismatches++;
    end
  endtask

  // Results are checked before the same-edge request is predicted; a result can
  // never belong to a request accepted at the same edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_replies.size() == 0) begin
          $error("result transfer with no request outstanding");
          mismatches++;
        end else begin
          want = expected_replies.pop_front();
          check_field("found", 32'(want.found), 32'(out_data.found));
          check_field("read_value", want.read_value, out_data.read_value);
          check_field("out_of_pages", 32'(want.out_of_pages), 32'(out_data.out_of_pages));
          check_field("min_id", want.min_id, out_data.min_id);
          check_field("max_id", want.max_id, out_data.max_id);
          replies_seen++;
          if (want.out_of_pages) refusals++;
        end
      end
      if (in_valid && in_ready) begin
        predicted        = predict_access(in_data);
        expected_replies = {expected_replies, predicted};
      end
      pending = expected_replies.size();
    end
  end

endmodule

// ===== bench/radix_page_map_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Radix page map testbench
// Drives lookups and inserts into the radix page map with random idling on
// both channels, and lets the reply checker compare every result.
// ----------------------------------------------------------------------------
module radix_page_map_tb;

  localparam int ID_WIDTH     = 32;
  localparam int LEVEL_BITS   = 8;
  localparam int PAGE_POOL    = 64;
  localparam int VALUE_WIDTH  = 32;

  // Number of random requests after the directed opening, and how many of the
  // last ones run with both sides idle-free.
  localparam int RANDOM_ITEMS = 1730;
  localparam int CALM_ITEMS   = 250;

  // The receiver holds off once for this many cycles, after this many requests
  // have been sent, so that the block backs up into its input channel.
  localparam int HOLD_CYCLES  = 300;
  localparam int HOLD_AFTER   = 400;

  logic clk;
  logic rst_n;

  rpm_chan_if #(.data_t(rpm_pkg::in_item_t))  in_chan ();
  rpm_chan_if #(.data_t(rpm_pkg::out_item_t)) out_chan ();

  int          mismatches;
  int          pending;
  int          replies_seen;
  int          refusals;

  int          sent_items = 0;
  int          lookups    = 0;
  int          inserts    = 0;
  bit          calm       = 1'b0;
  logic [31:0] recent_ids [$];

  radix_page_map #(
    .ID_WIDTH    (ID_WIDTH),
    .LEVEL_BITS  (LEVEL_BITS),
    .PAGE_POOL   (PAGE_POOL),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  rpm_reply_checker #(
    .ID_WIDTH    (ID_WIDTH),
    .LEVEL_BITS  (LEVEL_BITS),
    .PAGE_POOL   (PAGE_POOL),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_chan.valid),
    .in_ready     (in_chan.ready),
    .in_data      (in_chan.data),
    .out_valid    (out_chan.valid),
    .out_ready    (out_chan.ready),
    .out_data     (out_chan.data),
    .mismatches   (mismatches),
    .pending      (pending),
    .replies_seen (replies_seen),
    .refusals     (refusals)
  );

  // 8 ns clock period.
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Reset is held low from time zero and released on a falling edge. The block
  // then runs its clearing pass with the input held off; the sender simply
  // waits for ready, so no extra delay is needed here.
  initial begin
    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
  end

  // Hard stop. The slowest correct run (clearing pass, every request waiting
  // out the longest gaps on both sides plus the long hold) ends well before
  // this timeout.
  initial begin
    #4_000_000;
    $display("Verification failed");
    $finish;
  end

  // Offers one request and returns at the rising edge where it transferred.
  // Inputs only change on falling edges. When there is no gap, valid stays
  // high and only the payload changes, so valid never gets two updates in
  // one step.
  task automatic issue(logic kind, logic [31:0] id, logic [31:0] val);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(0, 2) == 0) gap = $urandom_range(1, 12);
    @(negedge clk);
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_chan.valid         <= 1'b1;
    in_chan.data.req_type <= kind;
    in_chan.data.id       <= id;
    in_chan.data.value    <= val;
    // Ready is sampled right at the edge, before the block updates it.
    do @(posedge clk); while (!in_chan.ready);
    sent_items++;
    if (kind == rpm_pkg::REQ_INSERT) begin
      inserts++;
      // Remember inserted ids so later requests can land on pages that exist.
      recent_ids = {recent_ids, id};
      if (recent_ids.size() > 48) void'(recent_ids.pop_front());
    end else begin
      lookups++;
    end
  endtask

  // Most random ids reuse an existing leaf page with a random entry, which is
  // where a walk goes all the way down. A few share only one or two upper
  // fields, or are fully random; those are the ones that allocate pages, so
  // the pool drains slowly and runs dry partway through the run. Once it is
  // nearly empty, inserts needing more pages than remain get refused.
  function automatic logic [31:0] pick_id();
    logic [31:0] base;
    int          r;
    r = $urandom_range(0, 99);
    if (recent_ids.size() == 0 || r < 3) return $urandom;
    base = recent_ids[$urandom_range(0, recent_ids.size() - 1)];
    if (r < 6) return {base[31:24], 24'($urandom)};
    if (r < 10) return {base[31:16], 16'($urandom)};
    if (r < 85) return {base[31:8], 8'($urandom)};
    return base;
  endfunction

  // Request stream.
  initial begin
    in_chan.valid = 1'b0;
    in_chan.data  = '0;
    wait (rst_n === 1'b1);

    // Directed opening. Lookups on the empty table, the first with a nonzero
    // value that must be ignored, then the first insert which builds a full path.
    issue(rpm_pkg::REQ_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF);
    issue(rpm_pkg::REQ_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
    issue(rpm_pkg::REQ_INSERT, 32'h1234_5678, 32'hFFFF_FFFF);
    issue(rpm_pkg::REQ_LOOKUP, 32'h1234_5678, 32'h0000_0000);
    // Same leaf page, entry never written: found with a zero value.
    issue(rpm_pkg::REQ_LOOKUP, 32'h1234_5679, 32'h0000_0000);
    // Leaf page missing, and two levels missing.
    issue(rpm_pkg::REQ_LOOKUP, 32'h1234_0078, 32'h0000_0000);
    issue(rpm_pkg::REQ_LOOKUP, 32'h12FF_0000, 32'h0000_0000);
    // Overwrite returns the old value.
    issue(rpm_pkg::REQ_INSERT, 32'h1234_5678, 32'h0000_0000);
    issue(rpm_pkg::REQ_LOOKUP, 32'h1234_5678, 32'h0000_0000);
    // Insert into the leaf page just used, then ones needing one and two pages.
    issue(rpm_pkg::REQ_INSERT, 32'h1234_5679, 32'hA5A5_A5A5);
    issue(rpm_pkg::REQ_INSERT, 32'h1234_5700, 32'h5A5A_5A5A);
    issue(rpm_pkg::REQ_INSERT, 32'h12AA_0001, 32'h0000_0001);
    // Id extremes, moving the running minimum and maximum, then MIN_ID_RESET.
    issue(rpm_pkg::REQ_INSERT, 32'h0000_0000, 32'hDEAD_BEEF);
    issue(rpm_pkg::REQ_INSERT, 32'hFFFF_FFFF, 32'h8000_0000);
    issue(rpm_pkg::REQ_INSERT, rpm_pkg::MIN_ID_RESET, 32'h7FFF_FFFF);
    issue(rpm_pkg::REQ_LOOKUP, 32'h0000_0000, 32'h0000_0000);
    issue(rpm_pkg::REQ_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
    issue(rpm_pkg::REQ_LOOKUP, rpm_pkg::MIN_ID_RESET, 32'h0000_0000);
    issue(rpm_pkg::REQ_LOOKUP, rpm_pkg::MIN_ID_RESET + 32'd1, 32'h0000_0000);
    issue(rpm_pkg::REQ_LOOKUP, 32'h1234_5700, 32'h0000_0000);

    // Random part: half inserts, half lookups.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i >= RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
      issue(logic'($urandom_range(0, 1)), pick_id(), $urandom);
    end

    @(negedge clk);
    in_chan.valid <= 1'b0;

    // Drain: every predicted reply must arrive, then a margin for stray ones.
    wait (pending == 0);
    repeat (30) @(posedge clk);

    $display("Run covered %0d lookups and %0d inserts, %0d results compared.",
             lookups, inserts, replies_seen);
    $display("Inserts refused because the page pool was exhausted: %0d.", refusals);
    if (mismatches == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Result side. Ready comes in random bursts, about a quarter of them low,
  // with an occasional long open stretch. One long hold-off happens once the
  // sender is well into the run; in the calm tail ready stays high.
  initial begin
    bit held;
    held = 1'b0;
    out_chan.ready = 1'b0;
    @(negedge clk);
    forever begin
      if (!calm && !held && sent_items >= HOLD_AFTER) begin
        out_chan.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        held = 1'b1;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_chan.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end else if ($urandom_range(0, 9) == 0) begin
        out_chan.ready <= 1'b1;
        repeat (40) @(negedge clk);
      end else begin
        out_chan.ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end
    end
  end

endmodule

// ===== filelist.f =====
rtl/rpm_pkg.sv
rtl/rpm_chan_if.sv
rtl/rpm_ram.sv
rtl/radix_page_map.sv
bench/rpm_reply_checker.sv
bench/radix_page_map_tb.sv
